// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the retry message queue.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock, off while in reset
`define AST_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock, off while in reset
`define AST_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/mcrmq_pkg.sv -----
// Shared types and constants of the multi-channel retry message queue.
// Depends on nothing; used by the slot RAM and the top level.
`timescale 1ns / 1ps

package mcrmq_pkg;

    // Default sizing
    localparam int unsigned CHANNELS_DEF    = 4;
    localparam int unsigned QUEUE_DEPTH_DEF = 32;

    // Field widths
    localparam int unsigned CH_FIELD_W = 2;
    localparam int unsigned CODE_W     = 16;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned RES_W      = 3;
    localparam int unsigned PING_W     = 2;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W  = 120;
    localparam int unsigned M_TDATA_W  = 120;
    localparam int unsigned M_PAD_W    = M_TDATA_W - (CH_FIELD_W + CODE_W + 3 * WORD_W + PING_W);

    // Operation kinds
    typedef enum logic [0:0] {
        OP_ENQUEUE = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    // Event result codes
    typedef enum logic [RES_W-1:0] {
        RES_IDLE      = 3'd0,
        RES_QUEUED    = 3'd1,
        RES_FULL      = 3'd2,
        RES_CONFIRMED = 3'd3,
        RES_RETRY     = 3'd4,
        RES_TIMEOUT   = 3'd5,
        RES_HELD      = 3'd6
    } res_t;

    // Ping outcome codes
    typedef enum logic [PING_W-1:0] {
        PING_NONE   = 2'd0,
        PING_QUEUED = 2'd1,
        PING_FULL   = 2'd2
    } ping_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PING_INTERVAL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PING_CHANNEL  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PING_CODE     = 8'd3;

    // Register reset values
    localparam logic [CNT_W-1:0]      RETRY_LIMIT_RST   = 8'd100;
    localparam logic [TICK_W-1:0]     PING_INTERVAL_RST = 16'd2500;
    localparam logic [CH_FIELD_W-1:0] PING_CHANNEL_RST  = 2'd3;
    localparam logic [CODE_W-1:0]     PING_CODE_RST     = 16'd0;

    // One stored slot: initial countdown and the message
    typedef struct packed {
        logic [CNT_W-1:0]  limit;
        logic [CODE_W-1:0] code;
        logic [WORD_W-1:0] user;
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] second;
    } slot_t;

endpackage

// ----- hw/rtl/multi_channel_retry_message_queue.sv -----
// Top level of the multi-channel retry message queue: control, pointers, result register.
// Depends on mcrmq_pkg, mcrmq_slot_ram and assert_macros.svh.
//
// Each input word is handled in a read step, which reads the polled channel's head slot
// from the slot RAMs (registered read port), and an update step, which updates pointers,
// occupancy and RAMs and loads the result register; the update step waits while an
// untaken result is held on m_tvalid. A new word is taken in the update cycle of the
// previous one. Slot occupancy lives in flip-flops cleared by reset, so there is no
// clearing pass and the block is ready right after reset. Configuration writes are always
// taken (cfg_ready is tied high) and must only be issued while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_channel_retry_message_queue
    import mcrmq_pkg::*;
#(
    parameter int unsigned CHANNELS    = CHANNELS_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // channel[1:0], message_code[17:2], user_word[49:18], first_arg[81:50],
    // second_arg[113:82], exchange_ok[114], link_hold[115], zero pad above
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  logic [0:0]            s_tuser,
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // event_channel[1:0], event_code[17:2], event_user[49:18], event_first[81:50],
    // event_second[113:82], ping_event[115:114], zero pad above
    output logic [M_TDATA_W-1:0]  m_tdata,
    // event_res[2:0]
    output logic [RES_W-1:0]      m_tuser,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned QD_W = $clog2(QUEUE_DEPTH);
    localparam logic [CH_W-1:0] LAST_CH  = CH_W'(CHANNELS - 1);
    localparam logic [QD_W-1:0] LAST_PTR = QD_W'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

    // Configuration registers
    logic [CNT_W-1:0]      retry_limit_reg;
    logic [TICK_W-1:0]     ping_interval_reg;
    logic [CH_FIELD_W-1:0] ping_channel_reg;
    logic [CODE_W-1:0]     ping_code_reg;

    // Input register
    op_t                   in_op_reg;
    logic [CH_FIELD_W-1:0] in_ch_reg;
    logic [CODE_W-1:0]     in_code_reg;
    logic [WORD_W-1:0]     in_user_reg;
    logic [WORD_W-1:0]     in_first_reg;
    logic [WORD_W-1:0]     in_second_reg;
    logic                  in_ok_reg;
    logic                  in_hold_reg;

    // Queue state
    logic [QD_W-1:0]        rp_reg     [CHANNELS];
    logic [QD_W-1:0]        rp_next    [CHANNELS];
    logic [QD_W-1:0]        wp_reg     [CHANNELS];
    logic [QD_W-1:0]        wp_next    [CHANNELS];
    logic [QUEUE_DEPTH-1:0] occ_reg    [CHANNELS];
    logic [QUEUE_DEPTH-1:0] occ_next   [CHANNELS];
    logic [QUEUE_DEPTH-1:0] touch_reg  [CHANNELS];
    logic [QUEUE_DEPTH-1:0] touch_next [CHANNELS];
    logic [CH_W-1:0]        poll_reg;
    logic [CH_W-1:0]        poll_next;
    logic [TICK_W-1:0]      tick_reg;
    logic [TICK_W-1:0]      tick_next;

    // Sequencer and result register
    state_t                state_reg;
    state_t                state_next;
    logic                  m_tvalid_reg;
    res_t                  out_res_reg;
    logic [CH_FIELD_W-1:0] out_ch_reg;
    logic [CODE_W-1:0]     out_code_reg;
    logic [WORD_W-1:0]     out_user_reg;
    logic [WORD_W-1:0]     out_first_reg;
    logic [WORD_W-1:0]     out_second_reg;
    ping_t                 out_ping_reg;

    // Result of the update cycle
    res_t                  res_d;
    logic [CH_FIELD_W-1:0] ech_d;
    logic [CODE_W-1:0]     ecode_d;
    logic [WORD_W-1:0]     euser_d;
    logic [WORD_W-1:0]     efirst_d;
    logic [WORD_W-1:0]     esecond_d;
    ping_t                 ping_d;

    // Handshake
    logic s_accept;
    logic exec_fire;

    // Store target (enqueue or ping)
    logic [CNT_W-1:0] limit_eff;
    logic             enq_ch_ok;
    logic             ping_ch_ok;
    logic [CH_W-1:0]  tgt_ch;
    logic             tgt_ok;
    logic [QD_W-1:0]  tgt_ptr;
    logic             tgt_win;
    slot_t            tgt_slot;
    logic             ping_due;
    logic             do_store;
    logic             do_tick;

    // Served head
    logic [QD_W-1:0]  srv_ptr;
    logic             srv_fwd;
    logic             srv_occ;
    slot_t            srv_slot;
    logic [CNT_W-1:0] srv_cnt;
    logic [CNT_W-1:0] srv_left;
    logic             srv_free;

    // RAM signals
    slot_t            pay_rdata;
    logic [CNT_W-1:0] cnt_rdata;
    logic             cnt_we;

    function automatic logic [QD_W-1:0] ptr_inc(input logic [QD_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + QD_W'(1);
    endfunction

    // Handshake
    assign exec_fire = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign s_tready  = (state_reg == ST_IDLE) || exec_fire;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg   <= RETRY_LIMIT_RST;
            ping_interval_reg <= PING_INTERVAL_RST;
            ping_channel_reg  <= PING_CHANNEL_RST;
            ping_code_reg     <= PING_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RETRY_LIMIT:   retry_limit_reg   <= cfg_data[CNT_W-1:0];
                REG_PING_INTERVAL: ping_interval_reg <= cfg_data[TICK_W-1:0];
                REG_PING_CHANNEL:  ping_channel_reg  <= cfg_data[CH_FIELD_W-1:0];
                REG_PING_CODE:     ping_code_reg     <= cfg_data[CODE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg     <= op_t'(s_tuser[0]);
            in_ch_reg     <= s_tdata[1:0];
            in_code_reg   <= s_tdata[17:2];
            in_user_reg   <= s_tdata[49:18];
            in_first_reg  <= s_tdata[81:50];
            in_second_reg <= s_tdata[113:82];
            in_ok_reg     <= s_tdata[114];
            in_hold_reg   <= s_tdata[115];
        end
    end

    // Pick the slot to store into: the offered message or the periodic ping
    assign limit_eff  = (retry_limit_reg == '0) ? CNT_W'(1) : retry_limit_reg;
    assign enq_ch_ok  = 32'(in_ch_reg) < CHANNELS;
    assign ping_ch_ok = 32'(ping_channel_reg) < CHANNELS;
    assign ping_due   = tick_reg >= ping_interval_reg;

    always_comb
    begin
        if (in_op_reg == OP_ENQUEUE)
        begin
            tgt_ok   = enq_ch_ok;
            tgt_ch   = enq_ch_ok ? CH_W'(in_ch_reg) : '0;
            tgt_slot = '{limit: limit_eff, code: in_code_reg, user: in_user_reg,
                         first: in_first_reg, second: in_second_reg};
        end
        else
        begin
            tgt_ok   = ping_ch_ok;
            tgt_ch   = ping_ch_ok ? CH_W'(ping_channel_reg) : '0;
            tgt_slot = '{limit: limit_eff, code: ping_code_reg, user: '0,
                         first: '0, second: '0};
        end
    end

    assign tgt_ptr  = wp_reg[tgt_ch];
    assign tgt_win  = tgt_ok && !occ_reg[tgt_ch][tgt_ptr];
    assign do_tick  = exec_fire && (in_op_reg == OP_TICK) && !in_hold_reg;
    assign do_store = exec_fire && tgt_win
                      && ((in_op_reg == OP_ENQUEUE) || (!in_hold_reg && ping_due));

    // Serve the polled head; forward a ping stored into it in the same tick
    assign srv_ptr  = rp_reg[poll_reg];
    assign srv_fwd  = (in_op_reg == OP_TICK) && ping_due && tgt_win
                      && (tgt_ch == poll_reg) && (tgt_ptr == srv_ptr);
    assign srv_occ  = srv_fwd || occ_reg[poll_reg][srv_ptr];
    assign srv_slot = srv_fwd ? tgt_slot : pay_rdata;
    assign srv_cnt  = srv_fwd ? limit_eff
                      : (touch_reg[poll_reg][srv_ptr] ? cnt_rdata : pay_rdata.limit);
    assign srv_left = in_ok_reg ? '0 : srv_cnt - CNT_W'(1);
    assign srv_free = (srv_left == '0);
    assign cnt_we   = do_tick && srv_occ && !srv_free;

    // Next queue state: ping store first, then the serve
    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        occ_next   = occ_reg;
        touch_next = touch_reg;
        poll_next  = poll_reg;
        tick_next  = tick_reg;
        if (do_store)
        begin
            occ_next[tgt_ch][tgt_ptr]   = 1'b1;
            touch_next[tgt_ch][tgt_ptr] = 1'b0;
            wp_next[tgt_ch]             = ptr_inc(tgt_ptr);
        end
        if (do_tick)
        begin
            tick_next = ping_due ? '0 : tick_reg + TICK_W'(1);
            if (srv_occ)
            begin
                if (srv_free)
                begin
                    occ_next[poll_reg][srv_ptr] = 1'b0;
                    rp_next[poll_reg]           = ptr_inc(srv_ptr);
                end
                else
                begin
                    touch_next[poll_reg][srv_ptr] = 1'b1;
                end
            end
            poll_next = (poll_reg == LAST_CH) ? '0 : poll_reg + CH_W'(1);
        end
    end

    // Hold queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                rp_reg[i]    <= '0;
                wp_reg[i]    <= '0;
                occ_reg[i]   <= '0;
                touch_reg[i] <= '0;
            end
            poll_reg <= '0;
            tick_reg <= '0;
        end
        else
        begin
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            occ_reg   <= occ_next;
            touch_reg <= touch_next;
            poll_reg  <= poll_next;
            tick_reg  <= tick_next;
        end
    end

    // Form the result word
    always_comb
    begin
        res_d     = RES_IDLE;
        ech_d     = CH_FIELD_W'(poll_reg);
        ecode_d   = '0;
        euser_d   = '0;
        efirst_d  = '0;
        esecond_d = '0;
        ping_d    = PING_NONE;
        priority if (in_op_reg == OP_ENQUEUE)
        begin
            res_d     = tgt_win ? RES_QUEUED : RES_FULL;
            ech_d     = in_ch_reg;
            ecode_d   = in_code_reg;
            euser_d   = in_user_reg;
            efirst_d  = in_first_reg;
            esecond_d = in_second_reg;
        end
        else if (in_hold_reg)
        begin
            res_d = RES_HELD;
        end
        else
        begin
            if (ping_due)
            begin
                ping_d = tgt_win ? PING_QUEUED : PING_FULL;
            end
            if (srv_occ)
            begin
                ecode_d   = srv_slot.code;
                euser_d   = srv_slot.user;
                efirst_d  = srv_slot.first;
                esecond_d = srv_slot.second;
                priority if (in_ok_reg)
                begin
                    res_d = RES_CONFIRMED;
                end
                else if (srv_free)
                begin
                    res_d = RES_TIMEOUT;
                end
                else
                begin
                    res_d = RES_RETRY;
                end
            end
        end
    end

    // Sequencer: read the head, then update
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = s_accept ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            out_res_reg    <= RES_IDLE;
            out_ch_reg     <= '0;
            out_code_reg   <= '0;
            out_user_reg   <= '0;
            out_first_reg  <= '0;
            out_second_reg <= '0;
            out_ping_reg   <= PING_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                m_tvalid_reg   <= 1'b1;
                out_res_reg    <= res_d;
                out_ch_reg     <= ech_d;
                out_code_reg   <= ecode_d;
                out_user_reg   <= euser_d;
                out_first_reg  <= efirst_d;
                out_second_reg <= esecond_d;
                out_ping_reg   <= ping_d;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_res_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_ping_reg, out_second_reg, out_first_reg,
                       out_user_reg, out_code_reg, out_ch_reg};

    // Slot storage
    mcrmq_slot_ram #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .clk       (clk),
        .rd_en     (state_reg == ST_READ),
        .rd_ch     (poll_reg),
        .rd_ptr    (srv_ptr),
        .pay_rdata (pay_rdata),
        .cnt_rdata (cnt_rdata),
        .pay_we    (do_store),
        .pay_ch    (tgt_ch),
        .pay_ptr   (tgt_ptr),
        .pay_wdata (tgt_slot),
        .cnt_we    (cnt_we),
        .cnt_ch    (poll_reg),
        .cnt_ptr   (srv_ptr),
        .cnt_wdata (srv_left)
    );

    // Sequencing and result checks
    `AST_NEXT(a_accept_reads, clk, rst_n, s_tvalid && s_tready, state_reg == ST_READ, "accepted word did not start a head read")
    `AST_NEXT(a_read_then_exec, clk, rst_n, state_reg == ST_READ, state_reg == ST_EXEC, "head read not followed by update")
    `AST_NEXT(a_exec_loads_result, clk, rst_n, exec_fire, m_tvalid, "update cycle did not present a result")
    `AST_IMPL(a_held_no_ping, clk, rst_n, m_tvalid && (out_res_reg == RES_HELD), (out_ping_reg == PING_NONE) && (out_code_reg == '0), "held tick reported ping or payload")

endmodule

// ----- hw/rtl/mcrmq_slot_ram.sv -----
// Slot storage of the retry message queue: message RAM and countdown RAM.
// Depends on mcrmq_pkg; instantiated by the top level.
`timescale 1ns / 1ps

module mcrmq_slot_ram
    import mcrmq_pkg::*;
#(
    parameter int unsigned CHANNELS    = CHANNELS_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int unsigned CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int unsigned QD_W       = $clog2(QUEUE_DEPTH)
)
(
    input  logic             clk,
    // shared read address
    input  logic             rd_en,
    input  logic [CH_W-1:0]  rd_ch,
    input  logic [QD_W-1:0]  rd_ptr,
    output slot_t            pay_rdata,
    output logic [CNT_W-1:0] cnt_rdata,
    // message write port
    input  logic             pay_we,
    input  logic [CH_W-1:0]  pay_ch,
    input  logic [QD_W-1:0]  pay_ptr,
    input  slot_t            pay_wdata,
    // countdown write port
    input  logic             cnt_we,
    input  logic [CH_W-1:0]  cnt_ch,
    input  logic [QD_W-1:0]  cnt_ptr,
    input  logic [CNT_W-1:0] cnt_wdata
);

    slot_t            pay_mem [CHANNELS][QUEUE_DEPTH];
    logic [CNT_W-1:0] cnt_mem [CHANNELS][QUEUE_DEPTH];

    // Write messages, read with registered data
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[pay_ch][pay_ptr] <= pay_wdata;
        end
        if (rd_en)
        begin
            pay_rdata <= pay_mem[rd_ch][rd_ptr];
        end
    end

    // Write decremented countdowns, read with registered data
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_ch][cnt_ptr] <= cnt_wdata;
        end
        if (rd_en)
        begin
            cnt_rdata <= cnt_mem[rd_ch][rd_ptr];
        end
    end

endmodule
